// ----- rtl/sxd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SysEx dump engine package
// Shared types, codes and the microcode program of the dump engine.
// ----------------------------------------------------------------------------
package sxd_pkg;

  // Default number of controller entries in the table.
  localparam int NUM_CONTROLS_DEF = 16;

  // Frame delimiters of a transmitted SysEx message.
  localparam logic [7:0] FRAME_START = 8'hF0;
  localparam logic [7:0] FRAME_END   = 8'hF7;

  // Reset values of the configuration registers.
  localparam logic [6:0] MAKER_RST     = 7'd125;
  localparam logic [6:0] DEVICE_RST    = 7'd0;
  localparam logic [6:0] REQ_CODE_RST  = 7'd1;
  localparam logic [6:0] DATA_CODE_RST = 7'd2;
  localparam logic [6:0] SCHEMA_RST    = 7'd1;

  // Byte counter saturation point.
  localparam logic [8:0] COUNT_MAX = 9'd511;

  // Positions of the body bytes as counted from the manufacturer byte.
  localparam logic [8:0] POS_MAKER    = 9'd0;
  localparam logic [8:0] POS_DEVICE   = 9'd1;
  localparam logic [8:0] POS_COMMAND  = 9'd2;
  localparam logic [8:0] POS_SCHEMA   = 9'd3;
  localparam logic [8:0] POS_CHANNEL  = 9'd4;
  localparam logic [8:0] POS_OCTAVE   = 9'd5;
  localparam logic [8:0] POS_VELOCITY = 9'd6;
  localparam logic [8:0] POS_DECLARED = 9'd7;
  localparam logic [8:0] POS_CONTROLS = 9'd8;

  // Shortest message body that can be judged at all.
  localparam logic [8:0] MIN_BODY = 9'd4;
  // Payload header plus checksum, counted from the manufacturer byte.
  localparam logic [9:0] MIN_DATA_BODY = 10'd9;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MANUFACTURER = 3'd0,
    REG_DEVICE       = 3'd1,
    REG_REQ_CODE     = 3'd2,
    REG_DATA_CODE    = 3'd3,
    REG_SCHEMA       = 3'd4
  } reg_index_t;

  // Message status codes.
  typedef enum logic [2:0] {
    ST_LOADED       = 3'd0,
    ST_DUMP_SENT    = 3'd1,
    ST_SHORT        = 3'd2,
    ST_BAD_MAKER    = 3'd3,
    ST_BAD_DEVICE   = 3'd4,
    ST_BAD_LENGTH   = 3'd5,
    ST_BAD_CHECKSUM = 3'd6,
    ST_UNKNOWN_CMD  = 3'd7
  } status_t;

  // Result kinds.
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_DUMP   = 1'b1;

  // Input and result payloads.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic       result_kind;
    logic [2:0] status;
    logic       load_ok;
    logic [7:0] tx_byte;
    logic       last_of_run;
  } result_t;

  // Source of the byte a microcode step sends.
  typedef enum logic [3:0] {
    SRC_STATUS    = 4'd0,
    SRC_START     = 4'd1,
    SRC_MAKER     = 4'd2,
    SRC_DEVICE    = 4'd3,
    SRC_DATA_CODE = 4'd4,
    SRC_SCHEMA    = 4'd5,
    SRC_CHANNEL   = 4'd6,
    SRC_OCTAVE    = 4'd7,
    SRC_VELOCITY  = 4'd8,
    SRC_COUNT     = 4'd9,
    SRC_CONTROL   = 4'd10,
    SRC_CHECKSUM  = 4'd11,
    SRC_END       = 4'd12
  } src_t;

  // Jump conditions of a microcode step.
  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_IDLE_HOLD = 3'd2,
    COND_NO_DUMP   = 3'd3,
    COND_MORE_CTL  = 3'd4
  } cond_t;

  // Program addresses.
  localparam logic [3:0] STEP_IDLE      = 4'd0;
  localparam logic [3:0] STEP_STATUS    = 4'd1;
  localparam logic [3:0] STEP_START     = 4'd2;
  localparam logic [3:0] STEP_MAKER     = 4'd3;
  localparam logic [3:0] STEP_DEVICE    = 4'd4;
  localparam logic [3:0] STEP_DATA_CODE = 4'd5;
  localparam logic [3:0] STEP_SCHEMA    = 4'd6;
  localparam logic [3:0] STEP_CHANNEL   = 4'd7;
  localparam logic [3:0] STEP_OCTAVE    = 4'd8;
  localparam logic [3:0] STEP_VELOCITY  = 4'd9;
  localparam logic [3:0] STEP_COUNT     = 4'd10;
  localparam logic [3:0] STEP_CONTROL   = 4'd11;
  localparam logic [3:0] STEP_CHECKSUM  = 4'd12;
  localparam logic [3:0] STEP_END       = 4'd13;

  // One control word of the program.
  typedef struct packed {
    logic       take;     // receive path open for body bytes
    logic       emit;     // step sends one result
    logic       close;    // judge the message, commit and clear it
    logic       last;     // final byte of a dump frame
    logic       cs_clr;   // restart checksum and table index
    logic       cs_acc;   // byte enters the frame checksum
    logic       ci_inc;   // advance the table index
    src_t       src;
    cond_t      cond;
    logic [3:0] target;
  } ucode_t;

  // Status seen by the sequencer when it picks the next step.
  typedef struct packed {
    logic take_last;
    logic slot_free;
    logic dump;
    logic more_ctl;
  } useq_cond_t;

  // Program store: one control word per step.
  function automatic ucode_t ucode_rom(logic [3:0] step);
    ucode_t w;
    w        = '0;
    w.src    = SRC_STATUS;
    w.cond   = COND_ALWAYS;
    w.target = STEP_IDLE;
    unique case (step)
      STEP_IDLE: begin
        w.take   = 1'b1;
        w.cond   = COND_IDLE_HOLD;
        w.target = STEP_IDLE;
      end
      STEP_STATUS: begin
        w.emit   = 1'b1;
        w.close  = 1'b1;
        w.cond   = COND_NO_DUMP;
        w.target = STEP_IDLE;
      end
      STEP_START: begin
        w.emit   = 1'b1;
        w.cs_clr = 1'b1;
        w.src    = SRC_START;
        w.cond   = COND_NEVER;
      end
      STEP_MAKER: begin
        w.emit = 1'b1;
        w.src  = SRC_MAKER;
        w.cond = COND_NEVER;
      end
      STEP_DEVICE: begin
        w.emit = 1'b1;
        w.src  = SRC_DEVICE;
        w.cond = COND_NEVER;
      end
      STEP_DATA_CODE: begin
        w.emit = 1'b1;
        w.src  = SRC_DATA_CODE;
        w.cond = COND_NEVER;
      end
      STEP_SCHEMA: begin
        w.emit   = 1'b1;
        w.cs_acc = 1'b1;
        w.src    = SRC_SCHEMA;
        w.cond   = COND_NEVER;
      end
      STEP_CHANNEL: begin
        w.emit   = 1'b1;
        w.cs_acc = 1'b1;
        w.src    = SRC_CHANNEL;
        w.cond   = COND_NEVER;
      end
      STEP_OCTAVE: begin
        w.emit   = 1'b1;
        w.cs_acc = 1'b1;
        w.src    = SRC_OCTAVE;
        w.cond   = COND_NEVER;
      end
      STEP_VELOCITY: begin
        w.emit   = 1'b1;
        w.cs_acc = 1'b1;
        w.src    = SRC_VELOCITY;
        w.cond   = COND_NEVER;
      end
      STEP_COUNT: begin
        w.emit   = 1'b1;
        w.cs_acc = 1'b1;
        w.src    = SRC_COUNT;
        w.cond   = COND_NEVER;
      end
      STEP_CONTROL: begin
        w.emit   = 1'b1;
        w.cs_acc = 1'b1;
        w.ci_inc = 1'b1;
        w.src    = SRC_CONTROL;
        w.cond   = COND_MORE_CTL;
        w.target = STEP_CONTROL;
      end
      STEP_CHECKSUM: begin
        w.emit = 1'b1;
        w.src  = SRC_CHECKSUM;
        w.cond = COND_NEVER;
      end
      STEP_END: begin
        w.emit   = 1'b1;
        w.last   = 1'b1;
        w.src    = SRC_END;
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        // Unused addresses fall back to the idle step.
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/sysex_config_dump_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SysEx configuration dump engine
// Receives SysEx bodies, checks IDs, lengths and checksum, commits settings
// and answers dump requests with a complete frame.
// ----------------------------------------------------------------------------
// Body bytes are taken one per cycle while the engine is idle. The final byte
// of a message is answered by a status result once the result register is
// free; for a dump request the microcode then sends the frame F0 .. F7 of
// 11 + NUM_CONTROLS bytes, one byte per cycle through the single result
// register while the result side takes them, so a dump request keeps the
// input closed until the end byte is sent. Any other message ends with its
// status result. Stalls on the result side stretch the run. Configuration
// writes are taken at any time and need no clearing pass after reset.
// ----------------------------------------------------------------------------
module sysex_config_dump_engine #(
  parameter int NUM_CONTROLS = sxd_pkg::NUM_CONTROLS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // Body byte channel.
  input  logic              item_valid,
  output logic              item_ready,
  input  sxd_pkg::item_t    item,
  // Result channel.
  output logic              result_valid,
  input  logic              result_ready,
  output sxd_pkg::result_t  result,
  // Configuration write channel.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [6:0]        cfg_data
);

  localparam int CI_W = (NUM_CONTROLS > 1) ? $clog2(NUM_CONTROLS) : 1;

  // Configuration registers.
  logic [6:0] maker_id;
  logic [6:0] unit_id;
  logic [6:0] dump_request_code;
  logic [6:0] dump_data_code;
  logic [6:0] schema_version;

  // Committed settings.
  logic [6:0] stored_channel;
  logic [6:0] stored_octave;
  logic [6:0] stored_velocity;
  logic [6:0] stored_controls [NUM_CONTROLS];

  // Settings buffered until the checksum passes.
  logic [6:0] pend_channel;
  logic [6:0] pend_octave;
  logic [6:0] pend_velocity;
  logic [6:0] pending_controls [NUM_CONTROLS];

  // Per-message receive state.
  logic [8:0] byte_count;
  logic [6:0] running_xor;
  logic [7:0] declared_controls;
  logic [7:0] received_checksum;
  logic [1:0] header_flags;
  logic [7:0] command_byte;

  // Frame generation state.
  logic [6:0]      frame_cs;
  logic [CI_W-1:0] ci;

  sxd_pkg::ucode_t     cw;
  sxd_pkg::useq_cond_t cond;
  sxd_pkg::status_t    msg_status;
  sxd_pkg::result_t    result_next;

  logic       item_fire;
  logic       slot_free;
  logic       step_fire;
  logic       is_dump;
  logic       is_load;
  logic [9:0] ctl_end;
  logic [9:0] data_min;
  logic [8:0] ctl_off;
  logic [7:0] frame_byte;

  // Sequencer.
  sxd_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .cond (cond),
    .cw   (cw)
  );

  assign item_ready = cw.take;
  assign cfg_ready  = 1'b1;
  assign item_fire  = item_valid && item_ready;
  assign slot_free  = !result_valid || result_ready;
  assign step_fire  = cw.emit && slot_free;

  assign cond.take_last = item_fire && item.last_byte;
  assign cond.slot_free = slot_free;
  assign cond.dump      = is_dump;
  assign cond.more_ctl  = (ci != CI_W'(NUM_CONTROLS - 1));

  // Receive-side position limits.
  assign ctl_end  = 10'({1'b0, sxd_pkg::POS_CONTROLS}) + 10'(declared_controls);
  assign data_min = sxd_pkg::MIN_DATA_BODY + 10'(declared_controls);
  assign ctl_off  = byte_count - sxd_pkg::POS_CONTROLS;

  // Message judgment, valid in the status step.
  always_comb begin
    if (byte_count < sxd_pkg::MIN_BODY) begin
      msg_status = sxd_pkg::ST_SHORT;
    end else if (!header_flags[0]) begin
      msg_status = sxd_pkg::ST_BAD_MAKER;
    end else if (!header_flags[1]) begin
      msg_status = sxd_pkg::ST_BAD_DEVICE;
    end else if (command_byte == {1'b0, dump_request_code}) begin
      msg_status = sxd_pkg::ST_DUMP_SENT;
    end else if (command_byte == {1'b0, dump_data_code}) begin
      if ({1'b0, byte_count} < data_min) begin
        msg_status = sxd_pkg::ST_BAD_LENGTH;
      end else if ({1'b0, running_xor} != received_checksum) begin
        msg_status = sxd_pkg::ST_BAD_CHECKSUM;
      end else begin
        msg_status = sxd_pkg::ST_LOADED;
      end
    end else begin
      msg_status = sxd_pkg::ST_UNKNOWN_CMD;
    end
  end

  assign is_dump = (msg_status == sxd_pkg::ST_DUMP_SENT);
  assign is_load = (msg_status == sxd_pkg::ST_LOADED);

  // Frame byte selected by the current step.
  always_comb begin
    unique case (cw.src)
      sxd_pkg::SRC_STATUS:    frame_byte = 8'h00;
      sxd_pkg::SRC_START:     frame_byte = sxd_pkg::FRAME_START;
      sxd_pkg::SRC_MAKER:     frame_byte = {1'b0, maker_id};
      sxd_pkg::SRC_DEVICE:    frame_byte = {1'b0, unit_id};
      sxd_pkg::SRC_DATA_CODE: frame_byte = {1'b0, dump_data_code};
      sxd_pkg::SRC_SCHEMA:    frame_byte = {1'b0, schema_version};
      sxd_pkg::SRC_CHANNEL:   frame_byte = {1'b0, stored_channel};
      sxd_pkg::SRC_OCTAVE:    frame_byte = {1'b0, stored_octave};
      sxd_pkg::SRC_VELOCITY:  frame_byte = {1'b0, stored_velocity};
      sxd_pkg::SRC_COUNT:     frame_byte = 8'(NUM_CONTROLS);
      sxd_pkg::SRC_CONTROL:   frame_byte = {1'b0, stored_controls[ci]};
      sxd_pkg::SRC_CHECKSUM:  frame_byte = {1'b0, frame_cs};
      sxd_pkg::SRC_END:       frame_byte = sxd_pkg::FRAME_END;
      default:                frame_byte = 8'h00;
    endcase
  end

  // Result word for the current step.
  always_comb begin
    if (cw.close) begin
      result_next.result_kind = sxd_pkg::KIND_STATUS;
      result_next.status      = msg_status;
      result_next.load_ok     = is_load;
      result_next.tx_byte     = 8'h00;
      result_next.last_of_run = !is_dump;
    end else begin
      result_next.result_kind = sxd_pkg::KIND_DUMP;
      result_next.status      = sxd_pkg::ST_DUMP_SENT;
      result_next.load_ok     = 1'b0;
      result_next.tx_byte     = frame_byte;
      result_next.last_of_run = cw.last;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      result <= result_next;
    end
  end

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      maker_id          <= sxd_pkg::MAKER_RST;
      unit_id           <= sxd_pkg::DEVICE_RST;
      dump_request_code <= sxd_pkg::REQ_CODE_RST;
      dump_data_code    <= sxd_pkg::DATA_CODE_RST;
      schema_version    <= sxd_pkg::SCHEMA_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sxd_pkg::reg_index_t'(cfg_index))
        sxd_pkg::REG_MANUFACTURER: maker_id          <= cfg_data;
        sxd_pkg::REG_DEVICE:       unit_id           <= cfg_data;
        sxd_pkg::REG_REQ_CODE:     dump_request_code <= cfg_data;
        sxd_pkg::REG_DATA_CODE:    dump_data_code    <= cfg_data;
        sxd_pkg::REG_SCHEMA:       schema_version    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-message receive state: updated per body byte, cleared at judgment.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count        <= '0;
      running_xor       <= '0;
      declared_controls <= '0;
      received_checksum <= '0;
      header_flags      <= '0;
      command_byte      <= '0;
    end else if (cw.close && step_fire) begin
      byte_count        <= '0;
      running_xor       <= '0;
      declared_controls <= '0;
      received_checksum <= '0;
      header_flags      <= '0;
      command_byte      <= '0;
    end else if (item_fire) begin
      if (byte_count != sxd_pkg::COUNT_MAX) begin
        byte_count <= byte_count + 9'd1;
      end
      priority if (byte_count == sxd_pkg::POS_MAKER) begin
        if (item.rx_byte == {1'b0, maker_id}) begin
          header_flags[0] <= 1'b1;
        end
      end else if (byte_count == sxd_pkg::POS_DEVICE) begin
        if (item.rx_byte == {1'b0, unit_id}) begin
          header_flags[1] <= 1'b1;
        end
      end else if (byte_count == sxd_pkg::POS_COMMAND) begin
        command_byte <= item.rx_byte;
      end else if (byte_count < sxd_pkg::POS_CONTROLS) begin
        running_xor <= running_xor ^ item.rx_byte[6:0];
        if (byte_count == sxd_pkg::POS_DECLARED) begin
          declared_controls <= item.rx_byte;
        end
      end else if ({1'b0, byte_count} < ctl_end) begin
        running_xor <= running_xor ^ item.rx_byte[6:0];
      end else if ({1'b0, byte_count} == ctl_end) begin
        received_checksum <= item.rx_byte;
      end else begin
        // Bytes past the checksum position are dropped.
      end
    end
  end

  // Pending buffers, written by the bytes of every message; only a loaded message commits them.
  always_ff @(posedge clk) begin
    if (item_fire) begin
      if (byte_count == sxd_pkg::POS_CHANNEL) begin
        pend_channel <= item.rx_byte[6:0];
      end
      if (byte_count == sxd_pkg::POS_OCTAVE) begin
        pend_octave <= item.rx_byte[6:0];
      end
      if (byte_count == sxd_pkg::POS_VELOCITY) begin
        pend_velocity <= item.rx_byte[6:0];
      end
      if (byte_count >= sxd_pkg::POS_CONTROLS && {1'b0, byte_count} < ctl_end
          && ctl_off < 9'(NUM_CONTROLS)) begin
        pending_controls[ctl_off[CI_W-1:0]] <= item.rx_byte[6:0];
      end
    end
  end

  // Commit of a message whose checksum passed.
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_channel  <= '0;
      stored_octave   <= '0;
      stored_velocity <= '0;
      for (int i = 0; i < NUM_CONTROLS; i++) begin
        stored_controls[i] <= '0;
      end
    end else if (cw.close && step_fire && is_load) begin
      stored_channel  <= pend_channel;
      stored_octave   <= pend_octave;
      stored_velocity <= pend_velocity;
      for (int i = 0; i < NUM_CONTROLS; i++) begin
        if (8'(i) < declared_controls) begin
          stored_controls[i] <= pending_controls[i];
        end
      end
    end
  end

  // Frame checksum and table index.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cs <= '0;
      ci       <= '0;
    end else if (step_fire) begin
      if (cw.cs_clr) begin
        frame_cs <= '0;
        ci       <= '0;
      end else begin
        if (cw.cs_acc) begin
          frame_cs <= frame_cs ^ frame_byte[6:0];
        end
        if (cw.ci_inc) begin
          ci <= ci + CI_W'(1);
        end
      end
    end
  end

  // A committed configuration is only ever reported on a loaded status.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.load_ok |->
      result.status == sxd_pkg::ST_LOADED && result.result_kind == sxd_pkg::KIND_STATUS)
    else $error("load_ok on a result that is not a loaded status");

  // A status that leaves the run open must be followed by a dump frame.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_kind == sxd_pkg::KIND_STATUS && !result.last_of_run |->
      result.status == sxd_pkg::ST_DUMP_SENT)
    else $error("open status result without a dump");

  // After the frame end byte is sent the engine takes body bytes again.
  assert property (@(posedge clk) disable iff (rst)
    step_fire && cw.src == sxd_pkg::SRC_END |=> item_ready)
    else $error("engine did not return to idle after a dump frame");

  // Body bytes are never taken while a message is being answered.
  assert property (@(posedge clk) disable iff (rst)
    item_ready |-> !cw.emit)
    else $error("input open during a sending step");

endmodule

// ----- rtl/sxd_useq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SysEx dump engine sequencer
// Step counter and program store; picks the next step from the control word's
// jump condition and holds a sending step while the result register is busy.
// ----------------------------------------------------------------------------
module sxd_useq (
  input  logic                   clk,
  input  logic                   rst,
  input  sxd_pkg::useq_cond_t    cond,
  output sxd_pkg::ucode_t        cw
);

  logic [3:0] step;
  logic [3:0] step_next;
  logic       jump;
  logic       stall;

  // Control word of the current step.
  always_comb begin
    cw = sxd_pkg::ucode_rom(step);
  end

  // Jump condition decode.
  always_comb begin
    unique case (cw.cond)
      sxd_pkg::COND_NEVER:     jump = 1'b0;
      sxd_pkg::COND_ALWAYS:    jump = 1'b1;
      sxd_pkg::COND_IDLE_HOLD: jump = !cond.take_last;
      sxd_pkg::COND_NO_DUMP:   jump = !cond.dump;
      sxd_pkg::COND_MORE_CTL:  jump = cond.more_ctl;
      default:                 jump = 1'b1;
    endcase
  end

  // A sending step waits until the result register can take its byte.
  always_comb begin
    stall = cw.emit && !cond.slot_free;
    if (stall) begin
      step_next = step;
    end else if (jump) begin
      step_next = cw.target;
    end else begin
      step_next = step + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= sxd_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ----- bench/sysex_config_dump_engine_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SysEx configuration dump engine testbench
// A short table of directed body bytes is followed by random messages in
// several register settings. Every accepted byte runs through an in-bench
// model of the engine, and each result transfer is compared field by field
// with the oldest outstanding reply. Both sides idle at random, and the
// result side holds off for long stretches so that the engine stalls its
// input.
// ----------------------------------------------------------------------------
module sysex_config_dump_engine_tb;

  localparam int NUM_CONTROLS = sxd_pkg::NUM_CONTROLS_DEF;
  localparam int FRAME_LEN    = 11 + NUM_CONTROLS;
  localparam int PHASE_ITEMS  = 12;

  // One row of the directed table; st is only meaningful where typed is set.
  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic             typed;
    sxd_pkg::status_t st;
  } plan_row_t;

  // Directed messages under the reset register values.
  localparam plan_row_t PLAN [26] = '{
    // One byte only: too short to judge.
    '{8'hF7, 1'b1, 1'b1, sxd_pkg::ST_SHORT},
    // Maker byte at its maximum does not match.
    '{8'hFF, 1'b0, 1'b0, sxd_pkg::ST_LOADED},
    '{8'h00, 1'b0, 1'b0, sxd_pkg::ST_LOADED},
    '{8'h01, 1'b0, 1'b0, sxd_pkg::ST_LOADED},
    '{8'h80, 1'b1, 1'b1, sxd_pkg::ST_BAD_MAKER},
    // Device byte 0x80 differs from device 0 in the upper bit alone.
    '{8'h7D, 1'b0, 1'b0, sxd_pkg::ST_LOADED},
    '{8'h80, 1'b0, 1'b0, sxd_pkg::ST_LOADED},
    '{8'h01, 1'b0, 1'b0, sxd_pkg::ST_LOADED},
    '{8'h00, 1'b1, 1'b1, sxd_pkg::ST_BAD_DEVICE},
    // Command 0x81 matches the request code only in its low bits.
    '{8'h7D, 1'b0, 1'b0, sxd_pkg::ST_LOADED},
    '{8'h00, 1'b0, 1'b0, sxd_pkg::ST_LOADED},
    '{8'h81, 1'b0, 1'b0, sxd_pkg::ST_LOADED},
    '{8'h00, 1'b1, 1'b1, sxd_pkg::ST_UNKNOWN_CMD},
    // Dump data with no controllers and a good checksum.
    '{8'h7D, 1'b0, 1'b0, sxd_pkg::ST_LOADED},
    '{8'h00, 1'b0, 1'b0, sxd_pkg::ST_LOADED},
    '{8'h02, 1'b0, 1'b0, sxd_pkg::ST_LOADED},
    '{8'h01, 1'b0, 1'b0, sxd_pkg::ST_LOADED},
    '{8'h05, 1'b0, 1'b0, sxd_pkg::ST_LOADED},
    '{8'h03, 1'b0, 1'b0, sxd_pkg::ST_LOADED},
    '{8'h7F, 1'b0, 1'b0, sxd_pkg::ST_LOADED},
    '{8'h00, 1'b0, 1'b0, sxd_pkg::ST_LOADED},
    '{8'h78, 1'b1, 1'b0, sxd_pkg::ST_LOADED},
    // Dump request that reads the settings back.
    '{8'h7D, 1'b0, 1'b0, sxd_pkg::ST_LOADED},
    '{8'h00, 1'b0, 1'b0, sxd_pkg::ST_LOADED},
    '{8'h01, 1'b0, 1'b0, sxd_pkg::ST_LOADED},
    '{8'h00, 1'b1, 1'b0, sxd_pkg::ST_LOADED}
  };

  // Clock, reset and ports.
  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             item_valid   = 1'b0;
  logic             item_ready;
  sxd_pkg::item_t   item         = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  sxd_pkg::result_t result;
  logic             cfg_valid    = 1'b0;
  logic             cfg_ready;
  logic [2:0]       cfg_index    = '0;
  logic [6:0]       cfg_data     = '0;

  // Register copies.
  logic [6:0] cfg_maker     = sxd_pkg::MAKER_RST;
  logic [6:0] cfg_device    = sxd_pkg::DEVICE_RST;
  logic [6:0] cfg_req_code  = sxd_pkg::REQ_CODE_RST;
  logic [6:0] cfg_data_code = sxd_pkg::DATA_CODE_RST;
  logic [6:0] cfg_schema    = sxd_pkg::SCHEMA_RST;

  // Committed settings and per-message receive state.
  logic [7:0] saved_channel  = '0;
  logic [7:0] saved_octave   = '0;
  logic [7:0] saved_velocity = '0;
  logic [7:0] saved_controls [NUM_CONTROLS] = '{default: '0};
  logic [7:0] pend_settings  [3] = '{default: '0};
  logic [7:0] pend_controls  [NUM_CONTROLS] = '{default: '0};
  logic [8:0] body_count     = '0;
  logic [7:0] body_xor       = '0;
  logic [7:0] ctl_declared   = '0;
  logic [7:0] body_checksum  = '0;
  logic [1:0] id_flags       = '0;
  logic [7:0] cmd_seen       = '0;
  logic       loaded_flag    = 1'b0;

  // Replies the engine still owes, oldest first.
  sxd_pkg::result_t outgoing_replies [$];
  sxd_pkg::result_t head_reply;
  int               mismatch_count = 0;

  // Sender and receiver pacing.
  logic [7:0] msg_q [$];
  int         items_sent = 0;
  int         burst_left = 0;
  bit         offering   = 1'b0;
  int         hold_req   = 0;
  int         hold_left  = 0;
  int         ready_mode = 0;
  int         mode_left  = 0;
  int         ready_tick = 0;

  sysex_config_dump_engine uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Print one mismatch and count it.
  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("MISMATCH %s: got 0x%02h, want 0x%02h at %0t ns", what, got, want, $time);
    mismatch_count++;
  endtask

  // Advance the engine model by one body byte and queue the replies it causes.
  task automatic absorb_body_byte(sxd_pkg::item_t it);
    logic [8:0]       idx;
    int               p;
    int               cks_pos;
    int               plen;
    int               lim;
    int               i;
    logic             dump;
    sxd_pkg::status_t st;
    logic [7:0]       frame [FRAME_LEN];
    logic [7:0]       cs;
    idx = body_count;
    // Header bytes are compared on arrival, payload bytes are buffered.
    if (idx == sxd_pkg::POS_MAKER) begin
      if (it.rx_byte == {1'b0, cfg_maker}) id_flags[0] = 1'b1;
    end else if (idx == sxd_pkg::POS_DEVICE) begin
      if (it.rx_byte == {1'b0, cfg_device}) id_flags[1] = 1'b1;
    end else if (idx == sxd_pkg::POS_COMMAND) begin
      cmd_seen = it.rx_byte;
    end else begin
      p = int'(idx) - 3;
      cks_pos = 5 + int'(ctl_declared);
      if (p <= 4) begin
        body_xor ^= it.rx_byte;
        if (p >= 1 && p <= 3) pend_settings[p - 1] = it.rx_byte;
        if (p == 4) ctl_declared = it.rx_byte;
      end else if (p < cks_pos) begin
        body_xor ^= it.rx_byte;
        if (p - 5 < NUM_CONTROLS) pend_controls[p - 5] = it.rx_byte;
      end else if (p == cks_pos) begin
        body_checksum = it.rx_byte;
      end
    end
    body_count = (idx < sxd_pkg::COUNT_MAX) ? idx + 9'd1 : sxd_pkg::COUNT_MAX;
    if (!it.last_byte) return;

    // Judge the message: length, maker, device, then command.
    loaded_flag = 1'b0;
    dump = 1'b0;
    plen = int'(body_count) - 3;
    if (body_count < sxd_pkg::MIN_BODY) begin
      st = sxd_pkg::ST_SHORT;
    end else if (!id_flags[0]) begin
      st = sxd_pkg::ST_BAD_MAKER;
    end else if (!id_flags[1]) begin
      st = sxd_pkg::ST_BAD_DEVICE;
    end else if (cmd_seen == {1'b0, cfg_req_code}) begin
      st = sxd_pkg::ST_DUMP_SENT;
      dump = 1'b1;
    end else if (cmd_seen == {1'b0, cfg_data_code}) begin
      if (plen < 6 + int'(ctl_declared)) begin
        st = sxd_pkg::ST_BAD_LENGTH;
      end else if ({1'b0, body_xor[6:0]} != body_checksum) begin
        st = sxd_pkg::ST_BAD_CHECKSUM;
      end else begin
        lim = (int'(ctl_declared) < NUM_CONTROLS) ? int'(ctl_declared) : NUM_CONTROLS;
        saved_channel  = pend_settings[0];
        saved_octave   = pend_settings[1];
        saved_velocity = pend_settings[2];
        for (i = 0; i < lim; i++) saved_controls[i] = pend_controls[i];
        loaded_flag = 1'b1;
        st = sxd_pkg::ST_LOADED;
      end
    end else begin
      st = sxd_pkg::ST_UNKNOWN_CMD;
    end
    outgoing_replies.push_back('{result_kind: sxd_pkg::KIND_STATUS, status: st,
                                 load_ok: loaded_flag, tx_byte: 8'h00,
                                 last_of_run: !dump});

    // A dump request is followed by the whole frame.
    if (dump) begin
      frame[0] = sxd_pkg::FRAME_START;
      frame[1] = {1'b0, cfg_maker};
      frame[2] = {1'b0, cfg_device};
      frame[3] = {1'b0, cfg_data_code};
      frame[4] = {1'b0, cfg_schema};
      frame[5] = {1'b0, saved_channel[6:0]};
      frame[6] = {1'b0, saved_octave[6:0]};
      frame[7] = {1'b0, saved_velocity[6:0]};
      frame[8] = 8'(NUM_CONTROLS) & 8'h7F;
      for (i = 0; i < NUM_CONTROLS; i++) frame[9 + i] = {1'b0, saved_controls[i][6:0]};
      cs = '0;
      for (i = 4; i < 9 + NUM_CONTROLS; i++) cs ^= frame[i];
      frame[9 + NUM_CONTROLS]  = {1'b0, cs[6:0]};
      frame[10 + NUM_CONTROLS] = sxd_pkg::FRAME_END;
      for (i = 0; i < FRAME_LEN; i++) begin
        outgoing_replies.push_back('{result_kind: sxd_pkg::KIND_DUMP,
                                     status: sxd_pkg::ST_DUMP_SENT,
                                     load_ok: 1'b0, tx_byte: frame[i],
                                     last_of_run: (i == FRAME_LEN - 1)});
      end
    end

    body_count    = '0;
    body_xor      = '0;
    ctl_declared  = '0;
    body_checksum = '0;
    id_flags      = '0;
    cmd_seen      = '0;
  endtask

  // Offer one byte, wait for its transfer, then maybe start a gap.
  task automatic send_item(sxd_pkg::item_t it, logic typed, sxd_pkg::status_t st);
    item_valid <= 1'b1;
    item       <= it;
    offering = 1'b1;
    do @(posedge clk); while (!item_ready);
    absorb_body_byte(it);
    if (typed) begin
      void'(outgoing_replies.pop_back());
      outgoing_replies.push_back('{result_kind: sxd_pkg::KIND_STATUS, status: st,
                                   load_ok: 1'b0, tx_byte: 8'h00, last_of_run: 1'b1});
    end
    items_sent++;
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 7);
    end else begin
      burst_left--;
    end
  endtask

  // Send the built message, marking its final byte.
  task automatic send_message();
    int i;
    for (i = 0; i < msg_q.size(); i++) begin
      send_item('{rx_byte: msg_q[i], last_byte: (i == msg_q.size() - 1)}, 1'b0,
                sxd_pkg::ST_LOADED);
    end
  endtask

  // Let every outstanding reply arrive, then idle the bench.
  task automatic drain_replies();
    if (offering) begin
      item_valid <= 1'b0;
      offering = 1'b0;
    end
    while (outgoing_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all five registers through the configuration channel.
  task automatic write_settings(logic [6:0] maker, logic [6:0] device, logic [6:0] req,
                                logic [6:0] data, logic [6:0] schema);
    sxd_pkg::reg_index_t regs [5];
    logic [6:0]          vals [5];
    int                  k;
    regs = '{sxd_pkg::REG_MANUFACTURER, sxd_pkg::REG_DEVICE, sxd_pkg::REG_REQ_CODE,
             sxd_pkg::REG_DATA_CODE, sxd_pkg::REG_SCHEMA};
    vals = '{maker, device, req, data, schema};
    for (k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[k];
      cfg_data  <= vals[k];
      do @(posedge clk); while (!cfg_ready);
      case (regs[k])
        sxd_pkg::REG_MANUFACTURER: cfg_maker     = vals[k];
        sxd_pkg::REG_DEVICE:       cfg_device    = vals[k];
        sxd_pkg::REG_REQ_CODE:     cfg_req_code  = vals[k];
        sxd_pkg::REG_DATA_CODE:    cfg_data_code = vals[k];
        sxd_pkg::REG_SCHEMA:       cfg_schema    = vals[k];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Matching maker and device bytes followed by a command byte.
  task automatic push_header(logic [7:0] cmd);
    msg_q.push_back({1'b0, cfg_maker});
    msg_q.push_back({1'b0, cfg_device});
    msg_q.push_back(cmd);
  endtask

  // Dump request with a few payload bytes that the engine ignores.
  task automatic build_request();
    push_header({1'b0, cfg_req_code});
    repeat ($urandom_range(1, 3)) msg_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Well-formed dump data with n controllers and the proper checksum.
  task automatic build_load(int n);
    logic [7:0] b;
    logic [7:0] x;
    int         i;
    push_header({1'b0, cfg_data_code});
    x = '0;
    for (i = 0; i < 5 + n; i++) begin
      b = (i == 4) ? 8'(n) : 8'($urandom_range(0, 255));
      x ^= b;
      msg_q.push_back(b);
    end
    msg_q.push_back({1'b0, x[6:0]});
  endtask

  // Pick one random message: a well-formed request or load, a broken one, or noise.
  task automatic build_message();
    int         r;
    int         n;
    logic [7:0] b;
    msg_q.delete();
    r = $urandom_range(0, 99);
    if (r < 22) begin
      build_request();
    end else if (r < 58) begin
      // Now and then declare at least as many controllers as the table holds.
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(NUM_CONTROLS, NUM_CONTROLS + 4)
                                      : $urandom_range(0, 4);
      build_load(n);
      if (r >= 50) begin
        // Corrupt one checksum bit; the upper bit gives a byte of 128 or more.
        b = msg_q.pop_back();
        msg_q.push_back(b ^ (8'd1 << $urandom_range(0, 7)));
      end else if (r >= 46) begin
        // Cut the tail so the declared length is not met.
        repeat ($urandom_range(1, 3)) void'(msg_q.pop_back());
      end else if ($urandom_range(0, 4) == 0) begin
        // Bytes past the checksum are ignored.
        repeat ($urandom_range(1, 2)) msg_q.push_back(8'($urandom_range(0, 255)));
      end
    end else if (r < 66) begin
      do b = 8'($urandom_range(0, 255)); while (b == {1'b0, cfg_maker});
      msg_q.push_back(b);
      msg_q.push_back({1'b0, cfg_device});
      repeat ($urandom_range(2, 5)) msg_q.push_back(8'($urandom_range(0, 255)));
    end else if (r < 74) begin
      msg_q.push_back({1'b0, cfg_maker});
      do b = 8'($urandom_range(0, 255)); while (b == {1'b0, cfg_device});
      msg_q.push_back(b);
      repeat ($urandom_range(2, 5)) msg_q.push_back(8'($urandom_range(0, 255)));
    end else if (r < 82) begin
      do b = 8'($urandom_range(0, 255));
      while (b == {1'b0, cfg_req_code} || b == {1'b0, cfg_data_code});
      push_header(b);
      repeat ($urandom_range(1, 4)) msg_q.push_back(8'($urandom_range(0, 255)));
    end else if (r < 90) begin
      repeat ($urandom_range(1, 3)) msg_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 8)) msg_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Result side: random stall patterns, plus long hold-offs on request.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(8, 40);
    end else begin
      mode_left--;
    end
    ready_tick++;
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      case (ready_mode)
        0:       result_ready <= 1'b1;
        1:       result_ready <= 1'($urandom_range(0, 1));
        2:       result_ready <= (ready_tick % 3 == 0);
        default: result_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Compare every result transfer with the oldest outstanding reply.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (outgoing_replies.size() == 0) begin
        report_mismatch("result with no reply outstanding", result.tx_byte, 8'h00);
      end else begin
        head_reply = outgoing_replies.pop_front();
        if (result.result_kind !== head_reply.result_kind)
          report_mismatch("result_kind", 8'(result.result_kind), 8'(head_reply.result_kind));
        if (result.status !== head_reply.status)
          report_mismatch("status", 8'(result.status), 8'(head_reply.status));
        if (result.load_ok !== head_reply.load_ok)
          report_mismatch("load_ok", 8'(result.load_ok), 8'(head_reply.load_ok));
        if (result.tx_byte !== head_reply.tx_byte)
          report_mismatch("tx_byte", result.tx_byte, head_reply.tx_byte);
        if (result.last_of_run !== head_reply.last_of_run)
          report_mismatch("last_of_run", 8'(result.last_of_run), 8'(head_reply.last_of_run));
      end
    end
  end

  // Main sequence: reset, directed table, then random phases.
  initial begin
    int ph;
    int k;
    int phase_start;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k < $size(PLAN); k++) begin
      send_item('{rx_byte: PLAN[k].data, last_byte: PLAN[k].last}, PLAN[k].typed, PLAN[k].st);
    end

    for (ph = 0; ph < 4; ph++) begin
      drain_replies();
      case (ph)
        0: write_settings(7'd0, 7'd127, 7'd0, 7'd127, 7'd0);
        // Both command codes equal: requests take precedence.
        1: write_settings(7'd127, 7'd0, 7'd127, 7'd127, 7'd127);
        default: write_settings(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                                7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                                7'($urandom_range(0, 127)));
      endcase
      // Hold the result side off across a dump while bytes keep coming.
      if (ph == 1 || ph == 3) begin
        hold_req = 150;
        msg_q.delete();
        build_request();
        send_message();
      end
      // One message with a long tail of bytes past the checksum.
      if (ph == 2) begin
        msg_q.delete();
        build_load(2);
        while (msg_q.size() < 16) msg_q.push_back(8'($urandom_range(0, 255)));
        send_message();
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        build_message();
        send_message();
      end
    end

    drain_replies();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sxd_pkg.sv
rtl/sxd_useq.sv
rtl/sysex_config_dump_engine.sv
bench/sysex_config_dump_engine_tb.sv
